@@ rtl/core/wpsq_pkg.sv @@
// Shared codes, timing constants and state types for the winch pickup sequencer.
package wpsq_pkg;

  // Winch job codes.
  localparam logic [1:0] JOB_IDLE  = 2'd0;
  localparam logic [1:0] JOB_PICK  = 2'd1;
  localparam logic [1:0] JOB_PLACE = 2'd2;

  // Winch phase codes.
  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;
  localparam logic [1:0] PH_3 = 2'd3;

  // Carriage mode codes.
  localparam logic [1:0] CAR_NORMAL  = 2'd0;
  localparam logic [1:0] CAR_DROPOFF = 2'd1;
  localparam logic [1:0] CAR_HOME    = 2'd2;

  // Gate position codes.
  localparam logic [1:0] GATE_CLOSED = 2'd0;
  localparam logic [1:0] GATE_OPEN   = 2'd1;
  localparam logic [1:0] GATE_PICKUP = 2'd2;

  // Motor command codes.
  localparam logic [1:0] WINCH_STOP  = 2'd0;
  localparam logic [1:0] WINCH_LVL_A = 2'd1;
  localparam logic [1:0] WINCH_LVL_B = 2'd2;
  localparam logic [1:0] DRIVE_OFF   = 2'd0;
  localparam logic [1:0] DRIVE_FWD   = 2'd1;
  localparam logic [1:0] DRIVE_REV   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_DUMMY_PERIOD = 2'd0;
  localparam logic [1:0] REG_GATE_PERIOD  = 2'd1;
  localparam logic [1:0] REG_WINCH_REV    = 2'd2;

  // Tick counts of the winch phases.
  localparam logic [4:0] PICK_DELAY   = 5'd20;
  localparam logic [4:0] SETTLE_PULSE = 5'd5;
  localparam logic [4:0] SETTLE_END   = 5'd10;
  localparam logic [4:0] PLACE_LOWER  = 5'd15;
  localparam logic [4:0] RELEASE_END  = 5'd10;
  localparam logic [4:0] PLACE_END    = 5'd15;
  localparam logic [1:0] RETRY_SAT    = 2'd3;
  localparam logic [3:0] WEIGHT_MAX   = 4'd15;
  localparam logic [8:0] REJECT_MAX   = 9'd511;

  // Held motor and flap commands.
  typedef struct packed {
    logic [1:0] winch;
    logic       magnet;
    logic [1:0] gate;
    logic       lock_in;
    logic       back_door;
    logic [1:0] carriage;
  } drive_t;

  // Sequencer state.
  typedef struct packed {
    logic [1:0] winch_job;
    logic [1:0] winch_phase;
    logic [4:0] delay_ticks;
    logic [1:0] retries;
    logic [7:0] nonmetal_ticks;
    logic       reject_pending;
    logic       gate_is_open;
    logic [8:0] reject_ticks;
    logic       object_flag;
    logic [1:0] carriage_mode;
    logic       return_started;
    logic       direction_toggle;
    logic [3:0] weights_held;
    logic       winch_reversed;
    drive_t     drive;
  } state_t;

  // State after reset: idle, gate closed, both flaps open, motors off.
  localparam state_t STATE_RESET = '{
    winch_job: JOB_IDLE, winch_phase: PH_0, delay_ticks: 5'd0, retries: 2'd0,
    nonmetal_ticks: 8'd0, reject_pending: 1'b0, gate_is_open: 1'b0,
    reject_ticks: 9'd0, object_flag: 1'b0, carriage_mode: CAR_NORMAL,
    return_started: 1'b0, direction_toggle: 1'b0, weights_held: 4'd0,
    winch_reversed: 1'b0,
    drive: '{winch: WINCH_STOP, magnet: 1'b0, gate: GATE_CLOSED, lock_in: 1'b1,
             back_door: 1'b1, carriage: DRIVE_OFF}
  };

endpackage

@@ rtl/core/winch_pickup_sequencer.sv @@
// Top level of the tick-driven winch pickup sequencer.
//
// Each item on the s_ stream is one tick: s_tuser selects a slow detection and
// winch tick (0) or a fast carriage tick (1), s_tdata carries the switch and
// sensor levels. Every item yields exactly one result item on the m_ stream
// with the held winch, magnet, gate, flap and carriage commands plus the
// single-tick twitch, pickup and searching pulses.
// The whole update is combinational between the state registers and the
// registered result, so one item is accepted per cycle while no result
// waits. While a result waits with m_tready low, s_tready is low and input
// stalls; a waiting result taken in the same cycle lets a new item in.
// The cfg channel writes dummy_period, gate_open_period and winch_reversed; cfg_ready is
// always high. Writes are to be made while no tick is in flight; the block itself does not enforce it.
// Reset (rst, synchronous) clears the sequencer, empties the result register,
// restores the register defaults and sets gate closed, flaps open, motors off.
module winch_pickup_sequencer #(
  parameter int unsigned RETRY_LIMIT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] metal_seen, [1] object_edge, [2] ir_high, [3] winch_top,
  // [4] rear_limit, [5] front_switch, [6] system_in_pickup, [7] zero
  input  logic [7:0]  s_tdata,
  // [0] mode
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] winch_cmd, [2] magnet_on, [4:3] gate_pos, [5] lock_flap_open,
  // [6] back_door_open, [8:7] carriage_drive, [9] twitch_pulse,
  // [10] have_weight, [11] set_pickup, [12] set_searching, [15:13] zero
  output logic [15:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam logic [1:0] RetryMax = 2'(RETRY_LIMIT);

  wpsq_pkg::state_t st;
  wpsq_pkg::state_t st_next;
  logic [7:0]       dummy_period;
  logic [7:0]       gate_open_period;
  logic             accept;
  logic             twitch;
  logic             pick;
  logic             search;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // One tick of the sequencer, in the order detect, gate, winch or carriage.
  always_comb begin
    logic       metal;
    logic       edge_in;
    logic       ir;
    logic       top;
    logic       rear;
    logic       front;
    logic       in_pickup;
    logic [1:0] lvl_down;
    logic [1:0] lvl_up;
    metal     = s_tdata[0];
    edge_in   = s_tdata[1];
    ir        = s_tdata[2];
    top       = s_tdata[3];
    rear      = s_tdata[4];
    front     = s_tdata[5];
    in_pickup = s_tdata[6];
    st_next   = st;
    twitch    = 1'b0;
    pick      = 1'b0;
    search    = 1'b0;
    lvl_down  = wpsq_pkg::WINCH_LVL_B;
    lvl_up    = wpsq_pkg::WINCH_LVL_A;

    if (edge_in) begin
      st_next.object_flag = 1'b1;
    end

    if (!s_tuser) begin
      // Metal and object detection with the non-metal timeout.
      if ((st_next.object_flag || metal) && st_next.winch_job == wpsq_pkg::JOB_IDLE &&
          st_next.carriage_mode == wpsq_pkg::CAR_NORMAL) begin
        if (metal) begin
          st_next.drive.lock_in = 1'b0;
          if (st_next.weights_held < wpsq_pkg::WEIGHT_MAX) begin
            st_next.weights_held = st_next.weights_held + 4'd1;
          end
          st_next.drive.back_door = 1'b0;
          st_next.winch_job       = wpsq_pkg::JOB_PICK;
          st_next.nonmetal_ticks  = '0;
        end else if (st_next.nonmetal_ticks < dummy_period && !in_pickup) begin
          st_next.nonmetal_ticks = st_next.nonmetal_ticks + 8'd1;
        end else if (st_next.nonmetal_ticks >= dummy_period && !in_pickup) begin
          st_next.reject_pending = 1'b1;
          st_next.nonmetal_ticks = '0;
        end
        st_next.object_flag = 1'b0;
      end
      if (!metal && st_next.nonmetal_ticks < dummy_period &&
          st_next.nonmetal_ticks != '0) begin
        st_next.nonmetal_ticks = st_next.nonmetal_ticks + 8'd1;
      end else if (st_next.nonmetal_ticks >= dummy_period) begin
        st_next.reject_pending = 1'b1;
        st_next.nonmetal_ticks = '0;
      end

      // Reject gate open timing.
      if (st_next.reject_pending) begin
        if (st_next.gate_is_open) begin
          if (st_next.reject_ticks < wpsq_pkg::REJECT_MAX) begin
            st_next.reject_ticks = st_next.reject_ticks + 9'd1;
          end
        end else begin
          st_next.drive.gate   = wpsq_pkg::GATE_OPEN;
          st_next.gate_is_open = 1'b1;
        end
      end
      if (st_next.reject_pending && st_next.reject_ticks > {1'b0, gate_open_period}) begin
        st_next.drive.gate     = wpsq_pkg::GATE_CLOSED;
        st_next.gate_is_open   = 1'b0;
        st_next.reject_ticks   = '0;
        st_next.reject_pending = 1'b0;
      end

      // Winch pick and place phases.
      unique case (st_next.winch_job)
        wpsq_pkg::JOB_PICK: begin
          unique case (st_next.winch_phase)
            wpsq_pkg::PH_0: begin
              st_next.drive.gate  = wpsq_pkg::GATE_PICKUP;
              st_next.delay_ticks = st_next.delay_ticks + 5'd1;
              if (st_next.delay_ticks > wpsq_pkg::PICK_DELAY) begin
                st_next.drive.winch  = st_next.winch_reversed ? lvl_up : lvl_down;
                st_next.drive.magnet = 1'b1;
                st_next.winch_phase  = wpsq_pkg::PH_1;
                pick                 = 1'b1;
                st_next.delay_ticks  = '0;
              end
            end
            wpsq_pkg::PH_1: begin
              if (top) begin
                st_next.drive.winch    = wpsq_pkg::WINCH_STOP;
                st_next.winch_reversed = !st_next.winch_reversed;
                st_next.winch_phase    = wpsq_pkg::PH_2;
              end
            end
            wpsq_pkg::PH_2: begin
              st_next.delay_ticks = st_next.delay_ticks + 5'd1;
              if (st_next.delay_ticks == wpsq_pkg::SETTLE_PULSE) begin
                st_next.drive.winch = st_next.winch_reversed ? lvl_up : lvl_down;
              end else if (st_next.delay_ticks >= wpsq_pkg::SETTLE_END) begin
                st_next.drive.winch = wpsq_pkg::WINCH_STOP;
                st_next.delay_ticks = '0;
                st_next.winch_phase = wpsq_pkg::PH_0;
                // Object still seen: retry with a twitch.
                if (metal || ir) begin
                  if (st_next.retries < wpsq_pkg::RETRY_SAT) begin
                    st_next.retries = st_next.retries + 2'd1;
                  end
                  twitch = 1'b1;
                end else begin
                  st_next.carriage_mode = wpsq_pkg::CAR_DROPOFF;
                  st_next.winch_job     = wpsq_pkg::JOB_IDLE;
                end
                // Too many retries: abort and reject the object.
                if (st_next.retries >= RetryMax) begin
                  st_next.winch_job      = wpsq_pkg::JOB_IDLE;
                  st_next.retries        = '0;
                  st_next.reject_pending = 1'b1;
                  if (st_next.weights_held != '0) begin
                    st_next.weights_held = st_next.weights_held - 4'd1;
                  end
                  search                = 1'b1;
                  st_next.drive.lock_in = 1'b1;
                end
              end
            end
            default: begin
              st_next.winch_phase = wpsq_pkg::PH_0;
            end
          endcase
        end
        wpsq_pkg::JOB_PLACE: begin
          unique case (st_next.winch_phase)
            wpsq_pkg::PH_0: begin
              st_next.drive.winch = st_next.winch_reversed ? lvl_up : lvl_down;
              st_next.delay_ticks = st_next.delay_ticks + 5'd1;
              if (st_next.delay_ticks >= wpsq_pkg::PLACE_LOWER) begin
                st_next.drive.winch  = wpsq_pkg::WINCH_STOP;
                st_next.drive.magnet = 1'b0;
                st_next.delay_ticks  = '0;
                st_next.winch_phase  = wpsq_pkg::PH_1;
              end
            end
            wpsq_pkg::PH_1: begin
              st_next.delay_ticks = st_next.delay_ticks + 5'd1;
              if (st_next.delay_ticks >= wpsq_pkg::RELEASE_END) begin
                st_next.drive.winch = st_next.winch_reversed ? lvl_down : lvl_up;
                st_next.delay_ticks = '0;
                st_next.winch_phase = wpsq_pkg::PH_2;
              end
            end
            wpsq_pkg::PH_2: begin
              if (top) begin
                st_next.drive.winch = wpsq_pkg::WINCH_STOP;
                st_next.winch_phase = wpsq_pkg::PH_3;
              end
            end
            default: begin
              st_next.delay_ticks = st_next.delay_ticks + 5'd1;
              if (st_next.delay_ticks == wpsq_pkg::SETTLE_PULSE) begin
                st_next.drive.winch = st_next.winch_reversed ? lvl_up : lvl_down;
              end else if (st_next.delay_ticks >= wpsq_pkg::PLACE_END) begin
                st_next.drive.winch   = wpsq_pkg::WINCH_STOP;
                st_next.delay_ticks   = '0;
                st_next.carriage_mode = wpsq_pkg::CAR_HOME;
                st_next.winch_phase   = wpsq_pkg::PH_0;
                st_next.winch_job     = wpsq_pkg::JOB_IDLE;
                search                = 1'b1;
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end else begin
      // Carriage drop-off and home travel on the fast tick.
      unique case (st_next.carriage_mode)
        wpsq_pkg::CAR_DROPOFF: begin
          st_next.drive.lock_in    = 1'b1;
          st_next.direction_toggle = 1'b1;
          st_next.drive.carriage   = wpsq_pkg::DRIVE_REV;
          if (rear) begin
            st_next.drive.carriage = wpsq_pkg::DRIVE_OFF;
            st_next.carriage_mode  = wpsq_pkg::CAR_NORMAL;
            st_next.winch_job      = wpsq_pkg::JOB_PLACE;
          end
        end
        wpsq_pkg::CAR_HOME: begin
          if (!st_next.return_started) begin
            st_next.direction_toggle = 1'b0;
            st_next.drive.carriage   = wpsq_pkg::DRIVE_FWD;
            st_next.return_started   = 1'b1;
          end else if (front) begin
            st_next.drive.carriage = wpsq_pkg::DRIVE_OFF;
            st_next.carriage_mode  = wpsq_pkg::CAR_NORMAL;
            search                 = 1'b1;
            st_next.return_started = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State, configuration and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st                      <= wpsq_pkg::STATE_RESET;
      dummy_period            <= 8'd100;
      gate_open_period        <= 8'd100;
      m_tvalid                <= 1'b0;
    end else begin
      if (accept) begin
        st <= st_next;
      end else if (cfg_valid && cfg_index == wpsq_pkg::REG_WINCH_REV) begin
        st.winch_reversed <= cfg_data[0];
      end
      if (cfg_valid && cfg_index == wpsq_pkg::REG_DUMMY_PERIOD) begin
        dummy_period <= cfg_data;
      end
      if (cfg_valid && cfg_index == wpsq_pkg::REG_GATE_PERIOD) begin
        gate_open_period <= cfg_data;
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, search, pick, st_next.weights_held != '0, twitch,
                  st_next.drive.carriage, st_next.drive.back_door,
                  st_next.drive.lock_in, st_next.drive.gate,
                  st_next.drive.magnet, st_next.drive.winch};
    end
  end

  // The reject gate is only open while a reject is pending.
  a_gate_pending: assert property (@(posedge clk) disable iff (rst)
    st.gate_is_open |-> st.reject_pending)
    else $error("reject gate open without a pending reject");

  // An abort clears the retry count in the same tick that reaches the limit.
  a_retry_bound: assert property (@(posedge clk) disable iff (rst)
    st.retries < RetryMax)
    else $error("retry count reached the limit");

  // Home travel flag only lives inside home mode.
  a_return_home: assert property (@(posedge clk) disable iff (rst)
    st.return_started |-> st.carriage_mode == wpsq_pkg::CAR_HOME)
    else $error("return flag set outside home travel");

  // The pickup pulse goes out together with the magnet.
  a_pick_magnet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> m_tdata[2])
    else $error("pickup pulse without magnet");

  // Delay counter stays within the longest phase.
  a_delay_bound: assert property (@(posedge clk) disable iff (rst)
    st.delay_ticks <= wpsq_pkg::PICK_DELAY + 5'd1)
    else $error("delay counter out of range");

endmodule
